[sv/rc4_stream_cipher_top_defines.svh]
// Assertion macros shared by the RC4 stream cipher RTL.
`ifndef RC4_STREAM_CIPHER_TOP_DEFINES_SVH
`define RC4_STREAM_CIPHER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define RC4_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RC4_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RC4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[sv/rc4sc_pkg.sv]
// Shared types and constants of the RC4 stream cipher.
package rc4sc_pkg;

    localparam int BYTE_W            = 8;
    localparam int SBOX_DEPTH        = 256;
    localparam int KEY_WORD_W        = 64;
    localparam int KEY_LEN_W         = 5;
    localparam int MAX_KEY_BYTES_DEF = 16;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_ADDR_W        = 5;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 5'd5;

    // Register indexes, taken from paddr[4:3].
    localparam logic [1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH   = 2'd1;
    localparam logic [1:0] REG_KEY_LENGTH = 2'd2;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

[sv/rc4_in_if.sv]
// Input channel: one data byte and the new-message flag.
interface rc4_in_if;
    import rc4sc_pkg::*;

    logic  valid;
    logic  ready;
    t_byte data_byte;
    logic  new_message;

    modport source (output valid, output data_byte, output new_message, input ready);
    modport sink   (input valid, input data_byte, input new_message, output ready);
endinterface

[sv/rc4_out_if.sv]
// Output channel: one combined byte.
interface rc4_out_if;
    import rc4sc_pkg::*;

    logic  valid;
    logic  ready;
    t_byte out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

[sv/rc4sc_ram.sv]
// Generic single-write, single-read RAM with registered, read-first output.
module rc4sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/rc4_stream_cipher_top.sv]
// RC4 stream cipher top level: S-box memory, sequencer and register port.
// A transfer without a key schedule reads S[i] and S[j], writes the swap and reads the
// keystream byte, then loads the output register once it has room; the block takes no
// new item until that byte is loaded. Each byte costs two dependent S-box reads, two
// swap writes and the keystream read on the one memory. A new message (or the first
// item after reset) adds the S-box fill and the 256 swap steps of the key schedule.
// Reset (synchronous, active low) clears the indices i and j, the schedule flag, the key
// registers (key length 5) and the output valid flag; the S-box holds no reset state.
module rc4_stream_cipher_top #(
    parameter int MAX_KEY_BYTES = rc4sc_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    rc4_in_if.sink                              i_in,
    rc4_out_if.source                           o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rc4sc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [rc4sc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [rc4sc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import rc4sc_pkg::*;
    `include "rc4_stream_cipher_top_defines.svh"

    localparam int KEY_IDX_W = $clog2(MAX_KEY_BYTES);
    localparam int ADDR_W    = $clog2(SBOX_DEPTH);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FILL  = 4'd1;
    localparam logic [3:0] ST_K_RDI = 4'd2;
    localparam logic [3:0] ST_K_RDJ = 4'd3;
    localparam logic [3:0] ST_K_WRI = 4'd4;
    localparam logic [3:0] ST_K_WRJ = 4'd5;
    localparam logic [3:0] ST_P_RDI = 4'd6;
    localparam logic [3:0] ST_P_RDJ = 4'd7;
    localparam logic [3:0] ST_P_WRI = 4'd8;
    localparam logic [3:0] ST_P_WRJ = 4'd9;
    localparam logic [3:0] ST_P_OUT = 4'd10;

    localparam logic [ADDR_W-1:0] LAST_ENTRY = ADDR_W'(SBOX_DEPTH - 1);

    // Configuration registers.
    logic [KEY_WORD_W-1:0] r_key_low;
    logic [KEY_WORD_W-1:0] r_key_high;
    logic [KEY_LEN_W-1:0]  r_key_length;

    // Sequencer and datapath registers.
    logic [3:0]           r_state,     n_state;
    logic                 r_scheduled, n_scheduled;
    logic [ADDR_W-1:0]    r_i,         n_i;
    logic [ADDR_W-1:0]    r_j,         n_j;
    logic [KEY_IDX_W-1:0] r_k,         n_k;
    logic [KEY_LEN_W-1:0] r_len,       n_len;
    t_byte                r_data,      n_data;
    t_byte                r_si,        n_si;
    t_byte                r_sj,        n_sj;
    logic [ADDR_W-1:0]    r_t,         n_t;
    logic                 r_out_valid, n_out_valid;
    t_byte                r_out_byte,  n_out_byte;

    // Memory port.
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    t_byte             w_wdata;
    logic [ADDR_W-1:0] w_raddr;
    t_byte             w_rdata;

    logic                      w_accept;
    logic                      w_cfg_wr;
    logic [KEY_LEN_W-1:0]      w_eff_len;
    logic [2*KEY_WORD_W-1:0]   w_key;
    t_byte                     w_key_byte;
    logic                      w_k_wrap;
    t_byte                     w_ks;
    logic                      w_out_free;

    rc4sc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Register port. Writes land on the access cycle; pready never stalls.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low    <= '0;
            r_key_high   <= '0;
            r_key_length <= KEY_LEN_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:3])
                REG_KEY_LOW:    r_key_low    <= pwdata;
                REG_KEY_HIGH:   r_key_high   <= pwdata;
                REG_KEY_LENGTH: r_key_length <= pwdata[KEY_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_KEY_LOW:    prdata = r_key_low;
            REG_KEY_HIGH:   prdata = r_key_high;
            REG_KEY_LENGTH: prdata = CFG_DATA_W'(r_key_length);
            default:        prdata = '0;
        endcase
    end

    // A zero length acts as one byte; lengths above the key storage saturate.
    always_comb begin
        w_eff_len = r_key_length;
        if (r_key_length == '0) begin
            w_eff_len = KEY_LEN_W'(1);
        end else if (r_key_length > KEY_LEN_W'(MAX_KEY_BYTES)) begin
            w_eff_len = KEY_LEN_W'(MAX_KEY_BYTES);
        end
    end

    assign w_key      = {r_key_high, r_key_low};
    assign w_key_byte = w_key[{r_k, 3'b000} +: BYTE_W];
    assign w_k_wrap   = (KEY_LEN_W'(r_k) + KEY_LEN_W'(1)) == r_len;

    // The keystream read is issued in the same cycle as the write of S[j], and the
    // memory returns the old data on that collision, so the written value is forwarded.
    assign w_ks = (r_t == r_j) ? r_si : w_rdata;

    // The output register takes a new byte when it is empty or being drained.
    assign w_out_free = !r_out_valid || o_out.ready;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_state     = r_state;
        n_scheduled = r_scheduled;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_len       = r_len;
        n_data      = r_data;
        n_si        = r_si;
        n_sj        = r_sj;
        n_t         = r_t;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        w_we        = 1'b0;
        w_waddr     = r_i;
        w_wdata     = r_i;
        w_raddr     = r_i;

        if (o_out.valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_data = i_in.data_byte;
                    if (i_in.new_message || !r_scheduled) begin
                        n_state = ST_FILL;
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_len   = w_eff_len;
                    end else begin
                        n_state = ST_P_RDI;
                    end
                end
            end
            // Identity fill, one entry per cycle.
            ST_FILL: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = r_i;
                n_i     = r_i + 1'b1;
                if (r_i == LAST_ENTRY) begin
                    n_state = ST_K_RDI;
                end
            end
            // Key schedule: each swap step runs through the states K_RDI, K_RDJ, K_WRI and K_WRJ.
            ST_K_RDI: begin
                w_raddr = r_i;
                n_state = ST_K_RDJ;
            end
            ST_K_RDJ: begin
                n_si    = w_rdata;
                n_j     = r_j + w_rdata + w_key_byte;
                w_raddr = n_j;
                n_state = ST_K_WRI;
            end
            ST_K_WRI: begin
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = w_rdata;
                n_state = ST_K_WRJ;
            end
            ST_K_WRJ: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_si;
                n_i     = r_i + 1'b1;
                n_k     = w_k_wrap ? '0 : r_k + 1'b1;
                if (r_i == LAST_ENTRY) begin
                    // i has wrapped to zero; j restarts for the keystream.
                    n_j         = '0;
                    n_scheduled = 1'b1;
                    n_state     = ST_P_RDI;
                end else begin
                    n_state = ST_K_RDI;
                end
            end
            // Keystream generation.
            ST_P_RDI: begin
                n_i     = r_i + 1'b1;
                w_raddr = n_i;
                n_state = ST_P_RDJ;
            end
            ST_P_RDJ: begin
                n_si    = w_rdata;
                n_j     = r_j + w_rdata;
                w_raddr = n_j;
                n_state = ST_P_WRI;
            end
            ST_P_WRI: begin
                n_sj    = w_rdata;
                w_we    = 1'b1;
                w_waddr = r_i;
                w_wdata = w_rdata;
                n_state = ST_P_WRJ;
            end
            ST_P_WRJ: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_si;
                n_t     = r_si + r_sj;
                w_raddr = n_t;
                n_state = ST_P_OUT;
            end
            // Holds the keystream read until the output register has room.
            ST_P_OUT: begin
                w_raddr = r_t;
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = r_data ^ w_ks;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scheduled <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scheduled <= n_scheduled;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_len      <= n_len;
        r_data     <= n_data;
        r_si       <= n_si;
        r_sj       <= n_sj;
        r_t        <= n_t;
        r_out_byte <= n_out_byte;
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;

    // The S-box is never written while the block waits for an item.
    `RC4_ASSERT_IMPL(a_no_write_idle, i_clk, i_rst_n, r_state == ST_IDLE, !w_we, "S-box written while idle")
    // Keystream generation only starts on a scheduled S-box.
    `RC4_ASSERT_IMPL(a_sched_before_ks, i_clk, i_rst_n, r_state == ST_P_RDI, r_scheduled, "keystream step without a key schedule")
    // A result appears only from the keystream read state.
    `RC4_ASSERT_IMPL(a_out_source, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == ST_P_OUT, "output loaded outside the keystream read")
    // Once a result is loaded, the sequencer is back waiting for input.
    `RC4_ASSERT_NEXT(a_out_then_idle, i_clk, i_rst_n, (r_state == ST_P_OUT) && w_out_free, r_state == ST_IDLE && r_out_valid, "sequencer did not return after loading a result")
endmodule
